@@ rtl/qvm_pkg.sv @@
// ----------------------------------------------------------------------------
// qvm_pkg: shared types and constants for the quad VCA cascade mixer
// Item layouts, register indexes, datapath widths and the elaboration-time
// generator for the exponential response table.
// ----------------------------------------------------------------------------
package qvm_pkg;

  // Channel count is fixed by the item layout below.
  localparam int unsigned CHAN_COUNT         = 4;
  localparam int unsigned EXP_TABLE_SIZE_DEF = 64;

  // Field and register widths.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned REG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Datapath widths.
  localparam int unsigned LIN_W = 15;                 // max(cv, 0), Q1.14
  localparam int unsigned FR_W  = 15;                 // interpolation fraction
  localparam int unsigned EXP_W = 18;                 // table entry, up to about 0.66 in Q.14
  localparam int unsigned F_W   = 18;                 // control factor, Q.14
  localparam int unsigned V_W   = 33;                 // audio times gain
  localparam int unsigned VF_W  = V_W + F_W + 1;      // audio times gain times factor
  localparam int unsigned CH_W  = 20;                 // one rounded channel value
  localparam int unsigned ACC_W = CH_W + $clog2(CHAN_COUNT) + 1;

  // Pipeline depth: seven lane stages, then the cascade and output stage.
  localparam int unsigned LANE_STAGES = 7;
  localparam int unsigned PIPE_STAGES = LANE_STAGES + 1;

  // Constants of the exponential table generator.
  localparam logic [63:0] LN200_HALF_Q24 = 64'd44445507;
  localparam logic [63:0] ONE_Q24        = 64'd16777216;
  localparam logic [63:0] EXP_DEN        = 64'd203776;   // 199 * 2^10
  localparam int unsigned TAYLOR_TERMS   = 60;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_CH1     = 3'd0,
    REG_GAIN_CH2     = 3'd1,
    REG_GAIN_CH3     = 3'd2,
    REG_GAIN_CH4     = 3'd3,
    REG_RESPONSE_CH1 = 3'd4,
    REG_RESPONSE_CH2 = 3'd5,
    REG_RESPONSE_CH3 = 3'd6,
    REG_RESPONSE_CH4 = 3'd7
  } cfg_reg_t;

  // One input item.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio_ch1;
    logic signed [SAMPLE_W-1:0] audio_ch2;
    logic signed [SAMPLE_W-1:0] audio_ch3;
    logic signed [SAMPLE_W-1:0] audio_ch4;
    logic signed [SAMPLE_W-1:0] control_ch1;
    logic signed [SAMPLE_W-1:0] control_ch2;
    logic signed [SAMPLE_W-1:0] control_ch3;
    logic signed [SAMPLE_W-1:0] control_ch4;
    logic [CHAN_COUNT-1:0]      control_plugged;
    logic [CHAN_COUNT-1:0]      output_plugged;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_out1;
    logic signed [SAMPLE_W-1:0] mix_out2;
    logic signed [SAMPLE_W-1:0] mix_out3;
    logic signed [SAMPLE_W-1:0] mix_out4;
  } out_item_t;

  // Restoring long division, one quotient bit per step. Only used to build
  // constant tables during elaboration.
  function automatic logic [63:0] elab_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem      = rem - {1'b0, den};
        quo[b]   = 1'b1;
      end
    end
    return quo;
  endfunction

  // Table entry k of n: (e^(k*ln(200)/2/n) - 1) * 10 / 199 in Q.14, with e^y
  // summed as a truncated Taylor series in Q.24.
  function automatic logic [EXP_W-1:0] exp_entry(input int unsigned k, input int unsigned n);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] num;
    logic        done;
    y    = elab_div(64'(k) * LN200_HALF_Q24, 64'(n));
    sum  = ONE_Q24;
    term = ONE_Q24;
    done = 1'b0;
    for (int unsigned t = 1; t <= TAYLOR_TERMS; t++) begin
      if (!done) begin
        term = elab_div((term * y) >> 24, 64'(t));
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          sum = sum + term;
        end
      end
    end
    num = (sum - ONE_Q24) * 64'd10;
    return EXP_W'((num + EXP_DEN / 2) / EXP_DEN);
  endfunction

endpackage

@@ rtl/qvm_lane.sv @@
// ----------------------------------------------------------------------------
// qvm_lane: one VCA channel
// Seven-stage pipeline: gain multiply, exponential table interpolation,
// linear/exponential crossfade, control multiply and symmetric rounding.
// ----------------------------------------------------------------------------
module qvm_lane #(
  parameter int unsigned EXP_TABLE_SIZE = qvm_pkg::EXP_TABLE_SIZE_DEF
) (
  input  logic                                 clk,
  input  logic [qvm_pkg::LANE_STAGES-1:0]      en,
  input  logic signed [qvm_pkg::SAMPLE_W-1:0]  audio,
  input  logic signed [qvm_pkg::SAMPLE_W-1:0]  control,
  input  logic                                 control_plugged,
  input  logic [qvm_pkg::REG_W-1:0]            gain,
  input  logic [qvm_pkg::REG_W-1:0]            response,
  output logic signed [qvm_pkg::CH_W-1:0]      ch
);

  localparam int unsigned TAB_N  = EXP_TABLE_SIZE + 1;
  localparam int unsigned TAB_AW = $clog2(TAB_N);
  localparam int unsigned IDX_W  = $clog2(EXP_TABLE_SIZE);
  localparam int unsigned T_W    = qvm_pkg::LIN_W + $clog2(TAB_N);
  localparam int unsigned PROD_W = qvm_pkg::EXP_W + qvm_pkg::FR_W;
  localparam int unsigned PE_W   = qvm_pkg::EXP_W + qvm_pkg::REG_W + 1;
  localparam int unsigned PL_W   = qvm_pkg::LIN_W + qvm_pkg::REG_W;
  localparam int unsigned FS_W   = PE_W + 1;

  // Exponential response table, built during elaboration.
  logic [qvm_pkg::EXP_W-1:0] exp_tab [TAB_N];

  for (genvar k = 0; k < TAB_N; k++) begin : g_tab
    localparam logic [qvm_pkg::EXP_W-1:0] ENTRY = qvm_pkg::exp_entry(k, EXP_TABLE_SIZE);
    assign exp_tab[k] = ENTRY;
  end

  // Stage registers. Plug flag, linear value and gained audio ride along.
  logic                              cvp [qvm_pkg::LANE_STAGES-1];
  logic signed [qvm_pkg::V_W-1:0]    v   [qvm_pkg::LANE_STAGES-1];
  logic [qvm_pkg::LIN_W-1:0]         lin [3];
  logic [qvm_pkg::FR_W-1:0]          fr  [2];
  logic [IDX_W-1:0]                  idx0;
  logic [qvm_pkg::EXP_W-1:0]         base1;
  logic [qvm_pkg::EXP_W-1:0]         diff1;
  logic [qvm_pkg::EXP_W-1:0]         e2;
  logic [PE_W-1:0]                   pe3;
  logic [PL_W-1:0]                   pl3;
  logic [qvm_pkg::F_W-1:0]           f4;
  logic signed [qvm_pkg::VF_W-1:0]   vf5;

  // Combinational terms between the registers.
  logic [qvm_pkg::LIN_W-1:0]         lin_next;
  logic [T_W-1:0]                    t_next;
  logic [TAB_AW-1:0]                 addr_lo;
  logic [TAB_AW-1:0]                 addr_hi;
  logic [PROD_W-1:0]                 interp_prod;
  logic [qvm_pkg::REG_W:0]           inv_resp;
  logic [FS_W-1:0]                   f_sum;
  logic                              neg_vf;
  logic [qvm_pkg::VF_W-1:0]          mag_vf;
  logic [qvm_pkg::VF_W-1:0]          rnd_vf;
  logic                              neg_v;
  logic [qvm_pkg::V_W-1:0]           mag_v;
  logic [qvm_pkg::V_W-1:0]           rnd_v;
  logic signed [qvm_pkg::CH_W-1:0]   ch_plug;
  logic signed [qvm_pkg::CH_W-1:0]   ch_unplug;

  // Negative control gives zero; the linear value never reaches the 2.0 clamp.
  assign lin_next = control[qvm_pkg::SAMPLE_W-1] ? '0 : control[qvm_pkg::LIN_W-1:0];
  assign t_next   = T_W'(lin_next) * T_W'(EXP_TABLE_SIZE);

  // The segment index always stays below the table size, so the upper
  // neighbor is always inside the table.
  assign addr_lo     = TAB_AW'(idx0);
  assign addr_hi     = TAB_AW'(idx0) + TAB_AW'(1);
  assign interp_prod = PROD_W'(diff1) * PROD_W'(fr[1]);
  assign inv_resp    = (qvm_pkg::REG_W+1)'(1 << qvm_pkg::REG_W) - {1'b0, response};
  assign f_sum       = FS_W'(pe3) + FS_W'(pl3) + FS_W'(1 << 15);

  // Round half away from zero: by 2^30 with the control factor, by 2^16 without.
  always_comb begin
    neg_vf    = vf5[qvm_pkg::VF_W-1];
    mag_vf    = neg_vf ? qvm_pkg::VF_W'(-vf5) : qvm_pkg::VF_W'(vf5);
    rnd_vf    = mag_vf + qvm_pkg::VF_W'(1 << 29);
    ch_plug   = neg_vf ? -$signed(rnd_vf[30 +: qvm_pkg::CH_W])
                       : $signed(rnd_vf[30 +: qvm_pkg::CH_W]);
    neg_v     = v[qvm_pkg::LANE_STAGES-2][qvm_pkg::V_W-1];
    mag_v     = neg_v ? qvm_pkg::V_W'(-v[qvm_pkg::LANE_STAGES-2])
                      : qvm_pkg::V_W'(v[qvm_pkg::LANE_STAGES-2]);
    rnd_v     = mag_v + qvm_pkg::V_W'(1 << 15);
    ch_unplug = neg_v ? -$signed(qvm_pkg::CH_W'(rnd_v[qvm_pkg::V_W-1:16]))
                      : $signed(qvm_pkg::CH_W'(rnd_v[qvm_pkg::V_W-1:16]));
  end

  // Pipeline registers, each stage loading when its enable is high.
  always_ff @(posedge clk) begin
    // Stage 0: gain multiply, linear value and table position.
    if (en[0]) begin
      v[0]   <= qvm_pkg::V_W'(audio * $signed({1'b0, gain}));
      cvp[0] <= control_plugged;
      lin[0] <= lin_next;
      idx0   <= t_next[qvm_pkg::FR_W +: IDX_W];
      fr[0]  <= t_next[qvm_pkg::FR_W-1:0];
    end
    // Stage 1: table lookup of the segment end points.
    if (en[1]) begin
      v[1]   <= v[0];
      cvp[1] <= cvp[0];
      lin[1] <= lin[0];
      fr[1]  <= fr[0];
      base1  <= exp_tab[addr_lo];
      diff1  <= exp_tab[addr_hi] - exp_tab[addr_lo];
    end
    // Stage 2: interpolate within the segment.
    if (en[2]) begin
      v[2]   <= v[1];
      cvp[2] <= cvp[1];
      lin[2] <= lin[1];
      e2     <= base1 + qvm_pkg::EXP_W'(interp_prod >> qvm_pkg::FR_W);
    end
    // Stage 3: weight exponential and linear by the response.
    if (en[3]) begin
      v[3]   <= v[2];
      cvp[3] <= cvp[2];
      pe3    <= PE_W'(e2) * PE_W'(inv_resp);
      pl3    <= PL_W'(lin[2]) * PL_W'(response);
    end
    // Stage 4: crossfaded control factor.
    if (en[4]) begin
      v[4]   <= v[3];
      cvp[4] <= cvp[3];
      f4     <= f_sum[16 +: qvm_pkg::F_W];
    end
    // Stage 5: apply the control factor.
    if (en[5]) begin
      v[5]   <= v[4];
      cvp[5] <= cvp[4];
      vf5    <= qvm_pkg::VF_W'(v[4] * $signed({1'b0, f4}));
    end
    // Stage 6: rounded channel value.
    if (en[6]) begin
      ch <= cvp[5] ? ch_plug : ch_unplug;
    end
  end

endmodule

@@ rtl/quad_vca_cascade_mixer.sv @@
// ----------------------------------------------------------------------------
// quad_vca_cascade_mixer: four VCAs feeding a cascading mix
// Per-channel gain and CV control with a linear/exponential response blend;
// channel values sum down to each plugged output and restart there.
// ----------------------------------------------------------------------------
// The block takes one item per clock while out_ready keeps the output moving;
// an item passes seven stages in each of the four parallel channel lanes (gain
// multiply, table lookup, interpolation, crossfade products, factor, control
// multiply, rounding), then one stage that forms the cascaded, saturated sums.
// Every stage has its own valid bit and loads whenever the stage after it is
// empty or moving, so bubbles close up while the output waits and the input
// stays open until the whole pipeline is full. Configuration writes take
// effect at once and are meant to be made while no item is in flight.
module quad_vca_cascade_mixer #(
  parameter int unsigned EXP_TABLE_SIZE = qvm_pkg::EXP_TABLE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  qvm_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output qvm_pkg::out_item_t                out_item,
  input  logic                              cfg_wr_en,
  input  logic [qvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qvm_pkg::REG_W-1:0]         cfg_data
);

  localparam int unsigned NCH = qvm_pkg::CHAN_COUNT;
  localparam int unsigned NST = qvm_pkg::PIPE_STAGES;
  localparam int unsigned NLS = qvm_pkg::LANE_STAGES;

  // Configuration registers.
  logic [qvm_pkg::REG_W-1:0] gain_reg [NCH];
  logic [qvm_pkg::REG_W-1:0] resp_reg [NCH];

  // Pipeline control.
  logic [NST-1:0]            vld_q;
  logic [NST-1:0]            en_v;
  logic                      in_acc;
  logic                      out_acc;

  // Item fields as per-channel arrays.
  logic signed [qvm_pkg::SAMPLE_W-1:0] audio_a   [NCH];
  logic signed [qvm_pkg::SAMPLE_W-1:0] control_a [NCH];
  logic signed [qvm_pkg::CH_W-1:0]     ch_a      [NCH];

  // Output plug mask riding along the lanes, and the output stage.
  logic [NCH-1:0]                      omask_q [NLS];
  logic signed [qvm_pkg::SAMPLE_W-1:0] mix_next [NCH];
  logic signed [qvm_pkg::SAMPLE_W-1:0] mix_q    [NCH];
  logic signed [qvm_pkg::ACC_W-1:0]    acc_c;

  assign audio_a[0]   = in_item.audio_ch1;
  assign audio_a[1]   = in_item.audio_ch2;
  assign audio_a[2]   = in_item.audio_ch3;
  assign audio_a[3]   = in_item.audio_ch4;
  assign control_a[0] = in_item.control_ch1;
  assign control_a[1] = in_item.control_ch2;
  assign control_a[2] = in_item.control_ch3;
  assign control_a[3] = in_item.control_ch4;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        gain_reg[i] <= '0;
        resp_reg[i] <= '1;
      end
    end else if (cfg_wr_en) begin
      unique case (qvm_pkg::cfg_reg_t'(cfg_index))
        qvm_pkg::REG_GAIN_CH1:     gain_reg[0] <= cfg_data;
        qvm_pkg::REG_GAIN_CH2:     gain_reg[1] <= cfg_data;
        qvm_pkg::REG_GAIN_CH3:     gain_reg[2] <= cfg_data;
        qvm_pkg::REG_GAIN_CH4:     gain_reg[3] <= cfg_data;
        qvm_pkg::REG_RESPONSE_CH1: resp_reg[0] <= cfg_data;
        qvm_pkg::REG_RESPONSE_CH2: resp_reg[1] <= cfg_data;
        qvm_pkg::REG_RESPONSE_CH3: resp_reg[2] <= cfg_data;
        qvm_pkg::REG_RESPONSE_CH4: resp_reg[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en_v[NST-1] = !vld_q[NST-1] || out_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en_v[s] = !vld_q[s] || en_v[s+1];
    end
  end

  assign in_ready  = en_v[0];
  assign out_valid = vld_q[NST-1];
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      if (en_v[0]) begin
        vld_q[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en_v[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Channel lanes.
  for (genvar i = 0; i < NCH; i++) begin : g_lane
    qvm_lane #(
      .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_lane (
      .clk             (clk),
      .en              (en_v[NLS-1:0]),
      .audio           (audio_a[i]),
      .control         (control_a[i]),
      .control_plugged (in_item.control_plugged[i]),
      .gain            (gain_reg[i]),
      .response        (resp_reg[i]),
      .ch              (ch_a[i])
    );
  end

  // Output plug mask delay line, matched to the lane depth.
  always_ff @(posedge clk) begin
    if (en_v[0]) begin
      omask_q[0] <= in_item.output_plugged;
    end
    for (int s = 1; s < NLS; s++) begin
      if (en_v[s]) begin
        omask_q[s] <= omask_q[s-1];
      end
    end
  end

  // Cascaded sum: each plugged output takes the sum so far and restarts it.
  always_comb begin
    acc_c = '0;
    for (int i = 0; i < NCH; i++) begin
      acc_c = acc_c + qvm_pkg::ACC_W'(ch_a[i]);
      if (omask_q[NLS-1][i]) begin
        if (acc_c > qvm_pkg::ACC_W'(32767)) begin
          mix_next[i] = 16'sh7fff;
        end else if (acc_c < -qvm_pkg::ACC_W'(32768)) begin
          mix_next[i] = -16'sh8000;
        end else begin
          mix_next[i] = acc_c[qvm_pkg::SAMPLE_W-1:0];
        end
        acc_c = '0;
      end else begin
        mix_next[i] = '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en_v[NST-1]) begin
      for (int i = 0; i < NCH; i++) begin
        mix_q[i] <= mix_next[i];
      end
    end
  end

  assign out_item.mix_out1 = mix_q[0];
  assign out_item.mix_out2 = mix_q[1];
  assign out_item.mix_out3 = mix_q[2];
  assign out_item.mix_out4 = mix_q[3];

  // An empty output stage means every stage can move, so input is open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  // Items in flight change only by what enters and what leaves.
  a_item_count: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(vld_q) ==
             $past($countones(vld_q)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("item lost or repeated in the pipeline");

  // Gain and response hold unless written.
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    !cfg_wr_en |=> $stable(gain_reg[0]) && $stable(gain_reg[1]) && $stable(gain_reg[2])
                   && $stable(gain_reg[3]) && $stable(resp_reg[0]) && $stable(resp_reg[1])
                   && $stable(resp_reg[2]) && $stable(resp_reg[3]))
    else $error("configuration changed without a write");

endmodule
